// ===== design/rfp_pkg.sv =====
package rfp_pkg;

    // ID queue geometry
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

    // Frame bytes and limits
    localparam logic [7:0] BYTE_STX     = 8'h02;
    localparam logic [7:0] BYTE_ETX     = 8'h03;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [3:0] FRAME_DIGITS = 4'd8;
    localparam logic [3:0] SKIP_DIGITS  = 4'd3;

    // Input modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE = 2'b00,
        CMD_PUSH = 2'b01,
        CMD_POP  = 2'b10
    } cmd_op_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] id_value;
        logic        id_valid;
        logic        fifo_empty;
        logic        overflow;
    } out_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic id_valid;
        logic fifo_empty;
        logic overflow;
    } flags_t;

endpackage

// ===== design/rfp_ram.sv =====
module rfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/rfp_parser.sv =====
module rfp_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  rfp_pkg::in_t  item,
    output rfp_pkg::cmd_t cmd
);

    logic        in_frame_reg, in_frame_next;
    logic [3:0]  digit_count_reg, digit_count_next;
    logic [16:0] partial_reg, partial_next;

    logic        is_digit;
    logic [7:0]  digit_off;
    logic [20:0] partial_x10;
    logic [20:0] partial_sum;

    // decimal fold: value * 10 + digit
    assign is_digit    = (item.rx_byte >= rfp_pkg::ASCII_ZERO) &&
                         (item.rx_byte <= rfp_pkg::ASCII_NINE);
    assign digit_off   = item.rx_byte - rfp_pkg::ASCII_ZERO;
    assign partial_x10 = {1'b0, partial_reg, 3'b000} + {3'b000, partial_reg, 1'b0};
    assign partial_sum = partial_x10 + {17'd0, digit_off[3:0]};

    // classify the beat and advance the frame state
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        digit_count_next = digit_count_reg;
        partial_next     = partial_reg;
        cmd.op           = rfp_pkg::CMD_NONE;
        cmd.value        = partial_reg[15:0];
        if (item.mode == rfp_pkg::MODE_READ)
        begin
            cmd.op = rfp_pkg::CMD_POP;
        end
        else if (!in_frame_reg)
        begin
            if (item.rx_byte == rfp_pkg::BYTE_STX)
            begin
                in_frame_next    = 1'b1;
                digit_count_next = 4'd0;
                partial_next     = 17'd0;
            end
        end
        else if (item.rx_byte == rfp_pkg::BYTE_ETX)
        begin
            in_frame_next = 1'b0;
            // complete frame with an ID that fits 16 bits
            if (digit_count_reg == rfp_pkg::FRAME_DIGITS && !partial_reg[16])
            begin
                cmd.op = rfp_pkg::CMD_PUSH;
            end
        end
        else if (is_digit && digit_count_reg < rfp_pkg::FRAME_DIGITS)
        begin
            digit_count_next = digit_count_reg + 4'd1;
            if (digit_count_reg >= rfp_pkg::SKIP_DIGITS)
            begin
                partial_next = partial_sum[16:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            digit_count_reg <= 4'd0;
            partial_reg     <= 17'd0;
        end
        else if (accept)
        begin
            in_frame_reg    <= in_frame_next;
            digit_count_reg <= digit_count_next;
            partial_reg     <= partial_next;
        end
    end

endmodule

// ===== design/rfp_cmd_queue.sv =====
module rfp_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  rfp_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output rfp_pkg::cmd_t rd_cmd
);

    rfp_pkg::cmd_t slot_reg [2];
    logic          wr_idx_reg;
    logic          rd_idx_reg;
    logic [1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_idx_reg];

    assign cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};

    // two-slot ring between parser and executor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_idx_reg <= ~wr_idx_reg;
            end
            if (rd_en)
            begin
                rd_idx_reg <= ~rd_idx_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_idx_reg] <= wr_cmd;
        end
    end

endmodule

// ===== design/rfp_id_fifo.sv =====
module rfp_id_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  rfp_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          empty,
    input  logic          pop,
    output rfp_pkg::out_t result
);

    logic [rfp_pkg::PTR_W-1:0] wptr_reg, rptr_reg;
    logic [rfp_pkg::CNT_W-1:0] count_reg, count_next;

    logic            r_valid_reg;
    rfp_pkg::flags_t r_flags_reg;
    logic [15:0]     rd_data;

    rfp_pkg::out_t oq_reg [2];
    logic          oq_wr_idx_reg, oq_rd_idx_reg;
    logic [1:0]    oq_cnt_reg;
    logic          oq_full, oq_push, oq_pop;
    rfp_pkg::out_t oq_in;

    logic fifo_full, has_data, exec, do_push, do_pop, push_drop, r_adv;

    // execute one command per cycle while the result stage has room
    assign oq_full   = (oq_cnt_reg == 2'd2);
    assign r_adv     = r_valid_reg && !oq_full;
    assign exec      = cmd_valid && (!r_valid_reg || !oq_full);
    assign cmd_take  = exec;
    assign fifo_full = (count_reg == rfp_pkg::CNT_FULL);
    assign has_data  = (count_reg != '0);
    assign do_push   = exec && (cmd.op == rfp_pkg::CMD_PUSH) && !fifo_full;
    assign push_drop = exec && (cmd.op == rfp_pkg::CMD_PUSH) && fifo_full;
    assign do_pop    = exec && (cmd.op == rfp_pkg::CMD_POP) && has_data;

    assign count_next = count_reg + {{(rfp_pkg::CNT_W-1){1'b0}}, do_push}
                                  - {{(rfp_pkg::CNT_W-1){1'b0}}, do_pop};

    rfp_ram #(
        .WIDTH (16),
        .DEPTH (rfp_pkg::FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wptr_reg),
        .wr_data (cmd.value),
        .rd_en   (do_pop),
        .rd_addr (rptr_reg),
        .rd_data (rd_data)
    );

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == rfp_pkg::PTR_LAST) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == rfp_pkg::PTR_LAST) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // result stage, aligned with the RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            r_valid_reg <= 1'b1;
        end
        else if (r_adv)
        begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            r_flags_reg.id_valid   <= do_pop;
            r_flags_reg.fifo_empty <= (count_next == '0);
            r_flags_reg.overflow   <= push_drop;
        end
    end

    // output queue toward the receiver
    assign oq_push             = r_adv;
    assign oq_pop              = pop && (oq_cnt_reg != 2'd0);
    assign oq_in.id_value      = r_flags_reg.id_valid ? rd_data : 16'd0;
    assign oq_in.id_valid      = r_flags_reg.id_valid;
    assign oq_in.fifo_empty    = r_flags_reg.fifo_empty;
    assign oq_in.overflow      = r_flags_reg.overflow;
    assign empty               = (oq_cnt_reg == 2'd0);
    assign result              = oq_reg[oq_rd_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_idx_reg <= 1'b0;
            oq_rd_idx_reg <= 1'b0;
            oq_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_idx_reg <= ~oq_wr_idx_reg;
            end
            if (oq_pop)
            begin
                oq_rd_idx_reg <= ~oq_rd_idx_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_idx_reg] <= oq_in;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rfp_pkg::CNT_FULL)
        else $error("ID queue occupancy above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("empty ID queue with unequal pointers");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |=> (r_valid_reg && r_flags_reg.id_valid))
        else $error("pop did not reach the result stage");

    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        push_drop |=> (r_flags_reg.overflow && $stable(wptr_reg)))
        else $error("dropped push not flagged or pointer moved");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= 2'd2)
        else $error("output queue overfilled");

endmodule

// ===== design/rfid_ascii_frame_parser_fifo_top.sv =====
// Reader frame parser with a tag ID queue.
// Input side: a queue write port. A beat is taken at a clock edge with push
// high and full low. item.mode 0 carries a received reader byte in
// item.rx_byte; mode 1 is a request to read one ID.
// Output side: a queue read port. While empty is low, result holds the
// oldest answer; pop high at an edge takes it. Every input beat yields
// exactly one result beat (id_value, id_valid, fifo_empty, overflow).
// Path: an input beat passes a command slot, then the ID store read and
// result register, then an output slot, before its result is visible.
// Throughput: one beat per cycle while full stays low, set by the parser,
// which classifies a beat as it is taken, and the ID store that serves one push or pop a cycle.
// Stall: when pop stays low, up to five answers buffer inside (two
// command slots, the result register, two output slots); then full rises
// and holds off the sender until the receiver drains.
// Reset: rst_n low clears the frame state, the ID queue pointers and all
// buffers; the queue starts empty and no frame is open.
module rfid_ascii_frame_parser_fifo_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  rfp_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output rfp_pkg::out_t result
);

    logic          accept;
    rfp_pkg::cmd_t front_cmd;
    rfp_pkg::cmd_t back_cmd;
    logic          back_valid;
    logic          back_take;

    assign accept = push && !full;

    // front: frame parsing and classification
    rfp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    // decoupling queue
    rfp_cmd_queue u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (back_take),
        .rd_valid (back_valid),
        .rd_cmd   (back_cmd)
    );

    // back: ID store and result delivery
    rfp_id_fifo u_idq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_take  (back_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
